@@ src/nhp_pkg.sv @@
// ----------------------------------------------------------------------------
// nhp_pkg
// Shared types and constants of the netpbm header parser.
// ----------------------------------------------------------------------------
package nhp_pkg;

	localparam int NUMBER_BITS_DEF = 32;
	localparam int POS_W           = 32;
	localparam int PIX_W           = 64;
	localparam int BYTE_W          = 8;
	localparam int FIELD_W         = 32;
	localparam int STATUS_W        = 3;
	localparam int CHAN_W          = 2;
	localparam int MAXVAL_OK       = 255;

	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
	localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CHAN_W-1:0] CHAN_GRAY = 2'd1;
	localparam logic [CHAN_W-1:0] CHAN_RGB  = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 3'd0,
		STATUS_MAGIC  = 3'd1,
		STATUS_NUMBER = 3'd2,
		STATUS_MAXVAL = 3'd3,
		STATUS_TRUNC  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_MAGIC_P,
		PH_MAGIC_D,
		PH_GAP,
		PH_COMMENT,
		PH_NUMBER,
		PH_PIXELS,
		PH_ERROR
	} parse_phase_t;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_MULT,
		SEQ_SCALE,
		SEQ_REPORT
	} seq_state_t;

	typedef enum logic [1:0] {
		NUM_WIDTH  = 2'd0,
		NUM_HEIGHT = 2'd1,
		NUM_MAXVAL = 2'd2
	} num_index_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    acc_load;
		logic    acc_step;
		logic    set_chan;
		logic    store_width;
		logic    store_height;
		logic    count_pos;
		logic    count_pix;
		logic    mult;
		logic    scale;
		logic    load_out;
		logic    clear;
		status_t status;
	} nhp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_space;
		logic is_hash;
		logic is_lf;
		logic is_p;
		logic is_magic_digit;
		logic acc_is_255;
		logic pix_enough;
		logic out_full;
	} nhp_stat_t;

endpackage

@@ src/nhp_in_if.sv @@
// ----------------------------------------------------------------------------
// nhp_in_if
// Input stream channel: one file byte per item with an end-of-file flag.
// ----------------------------------------------------------------------------
interface nhp_in_if;
	import nhp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] file_byte;
	logic              last_byte;

	modport source (output valid, output file_byte, output last_byte, input ready);
	modport sink (input valid, input file_byte, input last_byte, output ready);

endinterface

@@ src/nhp_out_if.sv @@
// ----------------------------------------------------------------------------
// nhp_out_if
// Result stream channel: parse status, geometry and pixel offset.
// ----------------------------------------------------------------------------
interface nhp_out_if;
	import nhp_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0]  image_width;
	logic [FIELD_W-1:0]  image_height;
	logic [CHAN_W-1:0]   channel_count;
	logic [FIELD_W-1:0]  pixel_offset;

	modport source (
		output valid, output status, output image_width, output image_height,
		output channel_count, output pixel_offset, input ready
	);
	modport sink (
		input valid, input status, input image_width, input image_height,
		input channel_count, input pixel_offset, output ready
	);

endinterface

@@ src/netpbm_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// netpbm_header_parser_core
// Streaming header parser for binary PGM (P5) and PPM (P6) files.
//
// Feed the file one byte per item with last_byte set on the final byte. The
// core takes one byte per cycle while a file streams in. After the final byte
// it closes input while it forms width times height in one multiplier stage,
// the channel scaling in a second and then loads the result register, waiting
// for the load only while an earlier result still waits on the output. It then
// returns one item with status, width, height, channel count and the byte
// offset of the first pixel, and is ready for the next file.
// ----------------------------------------------------------------------------
module netpbm_header_parser_core #(
	parameter int NUMBER_BITS = nhp_pkg::NUMBER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nhp_in_if.sink     in_ch,
	nhp_out_if.source  out_ch
);
	import nhp_pkg::*;

	nhp_cmd_t  cmd;
	nhp_stat_t stat;

	nhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_byte),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nhp_datapath #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.file_byte     (in_ch.file_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.status        (out_ch.status),
		.image_width   (out_ch.image_width),
		.image_height  (out_ch.image_height),
		.channel_count (out_ch.channel_count),
		.pixel_offset  (out_ch.pixel_offset)
	);

`ifndef SYNTHESIS
	// input closes right after the final byte
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_byte) |=> !in_ch.ready)
		else $error("input still open after final byte");

	// a fresh result follows its final byte through the multiply, scale and report states
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready && in_ch.last_byte, 4))
		else $error("result without matching final byte");

	// failed files report no geometry
	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status != STATUS_OK)) |->
		(out_ch.image_width == '0 && out_ch.image_height == '0 &&
		 out_ch.pixel_offset == '0))
		else $error("geometry reported with error status");
`endif

endmodule

@@ src/nhp_datapath.sv @@
// ----------------------------------------------------------------------------
// nhp_datapath
// Byte classification, number accumulator, geometry and counters, pixel
// size check and the result register.
// ----------------------------------------------------------------------------
module nhp_datapath #(
	parameter int NUMBER_BITS = nhp_pkg::NUMBER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [nhp_pkg::BYTE_W-1:0]       file_byte,
	input  nhp_pkg::nhp_cmd_t                cmd,
	output nhp_pkg::nhp_stat_t               stat,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [nhp_pkg::STATUS_W-1:0]     status,
	output logic [nhp_pkg::FIELD_W-1:0]      image_width,
	output logic [nhp_pkg::FIELD_W-1:0]      image_height,
	output logic [nhp_pkg::CHAN_W-1:0]       channel_count,
	output logic [nhp_pkg::FIELD_W-1:0]      pixel_offset
);
	import nhp_pkg::*;

	localparam int PROD_W = 2 * NUMBER_BITS;
	localparam int NEED_W = PROD_W + 2;
	localparam int CMP_W  = (NEED_W > PIX_W) ? NEED_W : PIX_W;

	logic [NUMBER_BITS-1:0] acc_q;
	logic [NUMBER_BITS-1:0] width_q;
	logic [NUMBER_BITS-1:0] height_q;
	logic                   three_q;
	logic [POS_W-1:0]       pos_q;
	logic [PIX_W-1:0]       pix_q;
	logic [PROD_W-1:0]      wh_s1;
	logic [NEED_W-1:0]      need_s2;

	logic [NUMBER_BITS-1:0] digit_val;
	logic [NUMBER_BITS-1:0] acc_next;
	logic [PROD_W-1:0]      wh_prod;
	logic [BYTE_W-1:0]      digit_raw;

	status_t            status_q;
	logic [FIELD_W-1:0] width_out_q;
	logic [FIELD_W-1:0] height_out_q;
	logic [CHAN_W-1:0]  chan_out_q;
	logic [FIELD_W-1:0] offset_out_q;
	logic               out_valid_q;

	// byte classes
	always_comb begin
		stat.is_digit       = file_byte inside {[CH_0:CH_9]};
		stat.is_space       = file_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
		stat.is_hash        = (file_byte == CH_HASH);
		stat.is_lf          = (file_byte == CH_LF);
		stat.is_p           = (file_byte == CH_P);
		stat.is_magic_digit = file_byte inside {CH_5, CH_6};
		stat.acc_is_255     = (acc_q == NUMBER_BITS'(MAXVAL_OK));
		stat.pix_enough     = CMP_W'(pix_q) >= CMP_W'(need_s2);
		stat.out_full       = out_valid_q;
	end

	assign digit_raw = file_byte - CH_0;
	assign digit_val = NUMBER_BITS'(digit_raw[3:0]);
	// times ten as two shifts, wrapping at the accumulator width
	assign acc_next  = (acc_q << 3) + (acc_q << 1) + digit_val;
	assign wh_prod   = width_q * height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			three_q  <= 1'b0;
			pos_q    <= '0;
			pix_q    <= '0;
		end else if (cmd.clear) begin
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			three_q  <= 1'b0;
			pos_q    <= '0;
			pix_q    <= '0;
		end else begin
			if (cmd.acc_load) begin
				acc_q <= digit_val;
			end else if (cmd.acc_step) begin
				acc_q <= acc_next;
			end
			if (cmd.store_width) begin
				width_q <= acc_q;
			end
			if (cmd.store_height) begin
				height_q <= acc_q;
			end
			if (cmd.set_chan) begin
				three_q <= (file_byte == CH_6);
			end
			if (cmd.count_pos && (pos_q != '1)) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.count_pix && (pix_q != '1)) begin
				pix_q <= pix_q + 1'b1;
			end
		end
	end

	// pixel byte requirement, two steps after the final byte
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			wh_s1 <= wh_prod;
		end
		if (cmd.scale) begin
			if (three_q) begin
				need_s2 <= {2'b00, wh_s1} + {1'b0, wh_s1, 1'b0};
			end else begin
				need_s2 <= {2'b00, wh_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q   <= cmd.status;
			chan_out_q <= three_q ? CHAN_RGB : CHAN_GRAY;
			if (cmd.status == STATUS_OK) begin
				width_out_q  <= FIELD_W'(width_q);
				height_out_q <= FIELD_W'(height_q);
				offset_out_q <= FIELD_W'(pos_q);
			end else begin
				width_out_q  <= '0;
				height_out_q <= '0;
				offset_out_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign image_width   = width_out_q;
	assign image_height  = height_out_q;
	assign channel_count = chan_out_q;
	assign pixel_offset  = offset_out_q;

endmodule

@@ src/nhp_ctrl.sv @@
// ----------------------------------------------------------------------------
// nhp_ctrl
// Header parse state machine and end-of-file report sequencer.
// ----------------------------------------------------------------------------
module nhp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  logic               out_ready,
	input  nhp_pkg::nhp_stat_t stat,
	output nhp_pkg::nhp_cmd_t  cmd
);
	import nhp_pkg::*;

	parse_phase_t phase_q, phase_d;
	seq_state_t   seq_q, seq_d;
	num_index_t   idx_q, idx_d;
	status_t      err_q, err_d;
	logic         accept;
	logic         report_go;
	status_t      final_status;

	assign accept    = in_valid && (seq_q == SEQ_RUN);
	assign report_go = (seq_q == SEQ_REPORT) && (!stat.out_full || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC_P;
			seq_q   <= SEQ_RUN;
			idx_q   <= NUM_WIDTH;
			err_q   <= STATUS_OK;
		end else begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			idx_q   <= idx_d;
			err_q   <= err_d;
		end
	end

	// status of a file whose last byte has been taken
	always_comb begin
		case (phase_q)
			PH_ERROR:                final_status = err_q;
			PH_MAGIC_P, PH_MAGIC_D:  final_status = STATUS_MAGIC;
			PH_GAP, PH_COMMENT:      final_status = STATUS_NUMBER;
			PH_NUMBER: begin
				if (idx_q != NUM_MAXVAL) begin
					final_status = STATUS_NUMBER;
				end else if (stat.acc_is_255) begin
					final_status = STATUS_TRUNC;
				end else begin
					final_status = STATUS_MAXVAL;
				end
			end
			PH_PIXELS: final_status = stat.pix_enough ? STATUS_OK : STATUS_TRUNC;
			default:   final_status = STATUS_NUMBER;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		idx_d   = idx_q;
		err_d   = err_q;
		case (seq_q)
			SEQ_RUN: begin
				if (accept) begin
					case (phase_q)
						PH_MAGIC_P: begin
							if (stat.is_p) begin
								phase_d = PH_MAGIC_D;
							end else begin
								phase_d = PH_ERROR;
								err_d   = STATUS_MAGIC;
							end
						end
						PH_MAGIC_D: begin
							if (stat.is_magic_digit) begin
								phase_d = PH_GAP;
							end else begin
								phase_d = PH_ERROR;
								err_d   = STATUS_MAGIC;
							end
						end
						PH_GAP: begin
							if (stat.is_hash) begin
								phase_d = PH_COMMENT;
							end else if (stat.is_digit) begin
								phase_d = PH_NUMBER;
							end else if (!stat.is_space) begin
								phase_d = PH_ERROR;
								err_d   = STATUS_NUMBER;
							end
						end
						PH_COMMENT: begin
							if (stat.is_lf) begin
								phase_d = PH_GAP;
							end
						end
						PH_NUMBER: begin
							if (!stat.is_digit) begin
								if (idx_q != NUM_MAXVAL) begin
									// terminator goes through the gap rules
									idx_d = (idx_q == NUM_WIDTH) ? NUM_HEIGHT : NUM_MAXVAL;
									if (stat.is_hash) begin
										phase_d = PH_COMMENT;
									end else if (stat.is_space) begin
										phase_d = PH_GAP;
									end else begin
										phase_d = PH_ERROR;
										err_d   = STATUS_NUMBER;
									end
								end else if (!stat.acc_is_255) begin
									phase_d = PH_ERROR;
									err_d   = STATUS_MAXVAL;
								end else begin
									phase_d = PH_PIXELS;
								end
							end
						end
						default: begin
						end
					endcase
					if (in_last) begin
						seq_d = SEQ_MULT;
					end
				end
			end
			SEQ_MULT:  seq_d = SEQ_SCALE;
			SEQ_SCALE: seq_d = SEQ_REPORT;
			SEQ_REPORT: begin
				if (report_go) begin
					seq_d   = SEQ_RUN;
					phase_d = PH_MAGIC_P;
					idx_d   = NUM_WIDTH;
					err_d   = STATUS_OK;
				end
			end
			default: seq_d = SEQ_RUN;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.status = final_status;
		in_ready   = (seq_q == SEQ_RUN);
		case (seq_q)
			SEQ_RUN: begin
				if (accept) begin
					cmd.count_pos = (phase_q != PH_PIXELS) && (phase_q != PH_ERROR);
					case (phase_q)
						PH_MAGIC_D: cmd.set_chan = stat.is_magic_digit;
						PH_GAP:     cmd.acc_load = stat.is_digit;
						PH_NUMBER: begin
							cmd.acc_step     = stat.is_digit;
							cmd.store_width  = !stat.is_digit && (idx_q == NUM_WIDTH);
							cmd.store_height = !stat.is_digit && (idx_q == NUM_HEIGHT);
						end
						PH_PIXELS:  cmd.count_pix = 1'b1;
						default: begin
						end
					endcase
				end
			end
			SEQ_MULT:  cmd.mult = 1'b1;
			SEQ_SCALE: cmd.scale = 1'b1;
			SEQ_REPORT: begin
				cmd.load_out = report_go;
				cmd.clear    = report_go;
			end
			default: begin
			end
		endcase
	end

endmodule
